FILE: rtl/core/b38_pkg.sv
// shared types, constants and helper functions for the base-38 stream encoder
// no dependencies
package b38_pkg;

  localparam int B38_COUNT_WIDTH = 16;
  localparam int B38_QDEPTH = 2;

  // floor(v / 38) = (v * B38_RECIP) >> B38_RECIP_SHIFT for every 24-bit v
  localparam logic [23:0] B38_RECIP = 24'd14128182;
  localparam int B38_RECIP_SHIFT = 29;
  localparam logic [5:0] B38_RADIX = 6'd38;

  localparam logic [15:0] B38_CAP_RESET = 16'hFFFF;
  localparam logic [2:0] B38_REG_CAPACITY = 3'd0;

  typedef struct packed {
    logic [23:0] value;
    logic [2:0]  ndig;
    logic        fin;
    logic        err;
  } job_t;

  function automatic logic [2:0] b38_digits(input logic [1:0] held);
    logic [2:0] n;
    case (held)
      2'd1: n = 3'd2;
      2'd2: n = 3'd4;
      2'd3: n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [6:0] b38_char(input logic [5:0] d);
    logic [6:0] c;
    if (d < 6'd10) begin
      c = 7'h30 + 7'(d);
    end else if (d < 6'd36) begin
      c = 7'h41 + 7'(d - 6'd10);
    end else if (d == 6'd36) begin
      c = 7'h2D;
    end else if (d == 6'd37) begin
      c = 7'h2E;
    end else begin
      c = 7'h00;
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/b38_front.sv
// front end: gathers bytes into chunks, checks output capacity, issues jobs
// depends on b38_pkg
module b38_front import b38_pkg::*; #(
  parameter int COUNT_WIDTH = B38_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  input  logic        in_final,
  output logic        in_ready,
  input  logic [15:0] capacity,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  localparam int SW = COUNT_WIDTH + 1;
  localparam int CMPW = (SW > 16) ? SW : 16;

  logic [23:0]            chunk;
  logic [1:0]             held;
  logic [COUNT_WIDTH-1:0] chars;
  logic                   ovf;

  logic        accept;
  logic [23:0] val_next;
  logic [1:0]  held_next;
  logic [2:0]  need;
  logic        complete;
  logic [SW-1:0] sum;
  logic        too_small;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  always_comb begin
    val_next = chunk | (24'(in_byte) << {held, 3'b000});
    held_next = held + 2'd1;
    complete = (held_next == 2'd3) || in_final;
    need = b38_digits(held_next);
    sum = {1'b0, chars} + SW'(need);
    too_small = (CMPW'(sum) >= CMPW'(capacity)) || sum[COUNT_WIDTH];
  end

  assign q_push = accept && !ovf && complete;
  assign q_job = '{value: val_next, ndig: need, fin: in_final, err: too_small};

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= '0;
      held <= '0;
      chars <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      if (ovf) begin
        if (in_final) begin
          ovf <= 1'b0;
          chars <= '0;
        end
      end else if (!complete) begin
        chunk <= val_next;
        held <= held_next;
      end else begin
        chunk <= '0;
        held <= '0;
        if (in_final) begin
          chars <= '0;
        end else if (too_small) begin
          ovf <= 1'b1;
        end else begin
          chars <= sum[COUNT_WIDTH-1:0];
        end
      end
    end
  end

endmodule

FILE: rtl/core/b38_queue.sv
// short job queue between front and back end
// depends on b38_pkg
module b38_queue import b38_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic avail,
  output job_t head
);

  localparam int AW = (B38_QDEPTH > 1) ? $clog2(B38_QDEPTH) : 1;

  job_t          mem [B38_QDEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;

  assign full = (count == (AW+1)'(B38_QDEPTH));
  assign avail = (count != '0);
  assign head = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(B38_QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(B38_QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/b38_back.sv
// back end: turns jobs into base-38 digits, one beat per cycle unless out_ready stalls the output register
// depends on b38_pkg
module b38_back import b38_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_avail,
  input  job_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_digit,
  output logic [6:0] out_char,
  output logic       out_chunk_end,
  output logic       out_msg_end,
  output logic       out_status
);

  logic        busy;
  logic [23:0] val;
  logic [2:0]  left;
  logic        fin;

  logic        slot_free;
  logic        emit;
  logic [23:0] cur_val;
  logic [2:0]  cur_left;
  logic        cur_fin;
  logic        cur_err;
  logic [47:0] prod;
  logic [23:0] quo;
  logic [23:0] quo38;
  logic [23:0] rem;
  logic [5:0]  dig;
  logic        last;

  assign slot_free = !out_valid || out_ready;
  assign emit = slot_free && (busy || q_avail);
  assign q_pop = slot_free && !busy && q_avail;

  always_comb begin
    cur_val = busy ? val : q_head.value;
    cur_left = busy ? left : q_head.ndig;
    cur_fin = busy ? fin : q_head.fin;
    cur_err = busy ? 1'b0 : q_head.err;
    prod = cur_val * B38_RECIP;
    quo = {5'b0, prod[47:B38_RECIP_SHIFT]};
    quo38 = (quo << 5) + (quo << 2) + (quo << 1);
    rem = cur_val - quo38;
    dig = rem[5:0];
    last = (cur_left == 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
      busy <= !cur_err && !last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      val <= quo;
      left <= cur_left - 3'd1;
      fin <= cur_fin;
      if (cur_err) begin
        out_digit <= '0;
        out_char <= '0;
        out_chunk_end <= 1'b0;
        out_msg_end <= 1'b1;
        out_status <= 1'b1;
      end else begin
        out_digit <= dig;
        out_char <= b38_char(dig);
        out_chunk_end <= last;
        out_msg_end <= last && cur_fin;
        out_status <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/base38_byte_stream_encoder.sv
// base-38 byte stream encoder, top level
// depends on b38_pkg, b38_front, b38_queue, b38_back
//
// slave stream: one message byte per beat in s_tdata, s_tlast on the last byte
// master stream: one character per beat, digit value and ascii code in
//   m_tdata, m_tuser carries chunk end and error flag, m_tlast ends a message
// apb port: output_capacity at address 0, written at psel&penable&pwrite
// bytes gather little-endian into 3-byte chunks; a full chunk gives 5
//   characters, a final partial chunk 4 or 2, least significant digit first
// if a chunk would not leave room for the terminator, one error beat goes out
//   and bytes are dropped up to the end of the message
// each chunk's job passes through the job queue, then the output register
// throughput: one input byte per cycle unless the 2-deep job queue is full,
//   one output beat per cycle from the digit unit unless m_tready is low;
//   sustained rate set by the single reciprocal multiplier, one digit a cycle
// reset clears all message state and sets output_capacity to 65535
// when m_tready is low the output register holds, the queue fills and
//   s_tready drops after two more chunks
module base38_byte_stream_encoder import b38_pkg::*; #(
  parameter int COUNT_WIDTH = B38_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // digit_value[5:0], ascii_char[12:6], zero
  output logic [1:0]  m_tuser,   // chunk_end[0], status[1]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] capacity;
  logic        q_full;
  logic        q_push;
  job_t        q_job;
  logic        q_avail;
  logic        q_pop;
  job_t        q_head;
  logic [5:0]  digit;
  logic [6:0]  char_code;
  logic        chunk_end;
  logic        status;

  assign pready = 1'b1;
  assign prdata = {16'b0, capacity};

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= B38_CAP_RESET;
    end else if (psel && penable && pwrite && pready
                 && ({paddr[2], 2'b00} == B38_REG_CAPACITY)) begin
      capacity <= pwdata[15:0];
    end
  end

  b38_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_byte(s_tdata),
    .in_final(s_tlast),
    .in_ready(s_tready),
    .capacity(capacity),
    .q_full(q_full),
    .q_push(q_push),
    .q_job(q_job)
  );

  b38_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_job(q_job),
    .full(q_full),
    .pop(q_pop),
    .avail(q_avail),
    .head(q_head)
  );

  b38_back u_back (
    .clk(clk),
    .rst(rst),
    .q_avail(q_avail),
    .q_head(q_head),
    .q_pop(q_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_digit(digit),
    .out_char(char_code),
    .out_chunk_end(chunk_end),
    .out_msg_end(m_tlast),
    .out_status(status)
  );

  assign m_tdata = {3'b000, char_code, digit};
  assign m_tuser = {status, chunk_end};

endmodule

FILE: rtl/core/b38_chk.sv
// port-level checks for the base-38 stream encoder
// depends on base38_byte_stream_encoder; bound to it below
module b38_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled beat changed");

  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && (m_tdata == 16'd0))
    else $error("error beat malformed");

  a_digit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> (m_tdata[5:0] < 6'd38) && (m_tdata[12:6] != 7'd0))
    else $error("digit out of range");

  a_msg_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && !m_tuser[1] |-> m_tuser[0])
    else $error("message end inside a chunk");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("beat valid after reset");

endmodule

bind base38_byte_stream_encoder b38_chk u_b38_chk (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tuser(m_tuser),
  .m_tlast(m_tlast)
);

FILE: bench/base38_byte_stream_encoder_tb.sv
`timescale 1ns / 100ps
// self-checking bench for base38_byte_stream_encoder: message bytes go in on the
// slave stream, every character beat is predicted and compared on the master stream
// depends on b38_pkg and the rtl top level base38_byte_stream_encoder
module base38_byte_stream_encoder_tb;
  import b38_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  typedef struct {
    logic [5:0] digit;
    logic [6:0] glyph;
    logic       chunk_end;
    logic       msg_end;
    logic       status;
  } char_beat_t;

  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // data_byte
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // digit_value[5:0], ascii_char[12:6], zero
  logic [1:0]  m_tuser;           // chunk_end[0], status[1]
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  byte_beat_t  byte_q[$];
  char_beat_t  char_q[$];

  string glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-.";

  // encoder model state
  logic [15:0] cap_model = B38_CAP_RESET;
  logic [23:0] chunk_acc = 24'd0;
  logic [1:0]  held = 2'd0;
  logic [15:0] written = 16'd0;
  logic        dropping = 1'b0;

  int fails = 0;
  int bytes_in = 0;
  int chars_out = 0;
  int overflow_beats = 0;
  int settings_used = 0;
  int burst_left = 0;
  int gap_left = 0;
  int quiet_cycles = 0;
  int stall_cnt = 0;
  bit steady_in = 1'b0;
  bit hold_input = 1'b0;
  logic [15:0] stall_pat = 16'hFFFF;

  base38_byte_stream_encoder u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fails++;
    if (fails <= 20) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    end
  endtask

  function automatic void clear_message_model();
    chunk_acc = 24'd0;
    held = 2'd0;
    written = 16'd0;
    dropping = 1'b0;
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    int unsigned need;
    int unsigned sum;
    logic [23:0] v;
    char_beat_t c;
    if (dropping) begin
      if (fin) clear_message_model();
      return;
    end
    chunk_acc = chunk_acc | (24'(b) << (8 * held));
    held = held + 2'd1;
    if (held != 2'd3 && !fin) return;
    need = (held == 2'd1) ? 2 : (held == 2'd2) ? 4 : 5;
    sum = written + need;
    if (sum >= cap_model || sum > ((1 << B38_COUNT_WIDTH) - 1)) begin
      c.digit = 6'd0;
      c.glyph = 7'd0;
      c.chunk_end = 1'b0;
      c.msg_end = 1'b1;
      c.status = 1'b1;
      char_q.push_back(c);
      overflow_beats++;
      if (fin) begin
        clear_message_model();
      end else begin
        chunk_acc = 24'd0;
        held = 2'd0;
        dropping = 1'b1;
      end
      return;
    end
    v = chunk_acc;
    for (int k = 0; k < int'(need); k++) begin
      c.digit = 6'(v % 38);
      c.glyph = 7'(glyphs[v % 38]);
      c.chunk_end = (k == int'(need) - 1);
      c.msg_end = (k == int'(need) - 1) && fin;
      c.status = 1'b0;
      char_q.push_back(c);
      v = v / 38;
    end
    written = 16'(sum);
    chunk_acc = 24'd0;
    held = 2'd0;
    if (fin) clear_message_model();
  endfunction

  // slave side: bursts of beats with random gaps, no gaps while steady_in is set
  always @(posedge clk) begin
    bit fire;
    bit next_valid;
    fire = s_tvalid && s_tready;
    next_valid = 1'b0;
    if (!rst) begin
      if (fire) begin
        encode_byte(s_tdata, s_tlast);
        void'(byte_q.pop_front());
        bytes_in++;
      end
      next_valid = s_tvalid && !fire;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_q.size() > 0 && !hold_input) begin
          next_valid = 1'b1;
          s_tdata <= byte_q[0].data;
          s_tlast <= byte_q[0].last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = steady_in ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    s_tvalid <= next_valid;
  end

  // master side: compare each beat with the oldest predicted character, drive random m_tready stalls
  always @(posedge clk) begin
    char_beat_t e;
    if (!rst && m_tvalid && m_tready) begin
      chars_out++;
      if (char_q.size() == 0) begin
        report_mismatch("beat with nothing expected", {m_tuser, m_tdata}, 32'd0);
      end else begin
        e = char_q.pop_front();
        if (m_tdata[5:0] != e.digit) report_mismatch("digit_value", m_tdata[5:0], e.digit);
        if (m_tdata[12:6] != e.glyph) report_mismatch("ascii_char", m_tdata[12:6], e.glyph);
        if (m_tdata[15:13] != 3'd0) report_mismatch("tdata pad", m_tdata[15:13], 0);
        if (m_tuser[0] != e.chunk_end) report_mismatch("chunk_end", m_tuser[0], e.chunk_end);
        if (m_tlast != e.msg_end) report_mismatch("message_end", m_tlast, e.msg_end);
        if (m_tuser[1] != e.status) report_mismatch("status", m_tuser[1], e.status);
      end
    end
    stall_cnt++;
    if (stall_cnt % 64 == 0) begin
      stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    end else begin
      stall_pat = {stall_pat[14:0], stall_pat[15]};
    end
    m_tready <= stall_pat[15];
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (byte_q.size() == 0 && char_q.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("base38_byte_stream_encoder regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [2:0] a, input logic [31:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= a;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata != want) report_mismatch("capacity readback", prdata, want);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capacity(input logic [15:0] cap);
    apb_write(B38_REG_CAPACITY, {16'd0, cap});
    cap_model = cap;
    settings_used++;
    apb_read_check(B38_REG_CAPACITY, {16'd0, cap});
  endtask

  task automatic push_byte(input logic [7:0] d, input logic last);
    byte_beat_t bb;
    bb.data = d;
    bb.last = last;
    byte_q.push_back(bb);
  endtask

  task automatic queue_messages(input int n_bytes, input int max_len);
    int len;
    @(negedge clk);
    while (n_bytes > 0) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, max_len) : $urandom_range(1, 7);
      for (int i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
      n_bytes -= len;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (byte_q.size() != 0 || s_tvalid || char_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [15:0] cap_plan [10];
    cap_plan = '{16'hFFFF, 16'd1, 16'd2, 16'd7, 16'd12,
                 16'($urandom_range(0, 40)), 16'($urandom_range(13, 400)), 16'd0,
                 16'($urandom), 16'hFFFF};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    apb_read_check(B38_REG_CAPACITY, {16'd0, B38_CAP_RESET});

    // single byte, two bytes, full chunks at both extremes, top digits
    @(negedge clk);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h24, 1'b1);
    push_byte(8'h25, 1'b1);
    wait_idle();

    // zero capacity always overflows
    set_capacity(16'd0);
    @(negedge clk);
    push_byte(8'hAA, 1'b1);
    wait_idle();

    // capacity 3: two chars fit, four do not
    set_capacity(16'd3);
    @(negedge clk);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_idle();

    // capacity 6: overflow mid message, dropped bytes, then a clean message
    set_capacity(16'd6);
    @(negedge clk);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h44, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h66, 1'b0);
    push_byte(8'h77, 1'b1);
    push_byte(8'h09, 1'b1);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      set_capacity(cap_plan[p]);
      steady_in = ($urandom_range(0, 3) == 0);
      queue_messages(28, (cap_plan[p] == 16'hFFFF) ? 60 : 30);
      if (p == 3) begin
        do @(negedge clk); while (byte_q.size() > 15);
        hold_input = 1'b1;
        do @(negedge clk); while (s_tvalid || char_q.size() != 0);
        hold_input = 1'b0;
      end
      wait_idle();
    end

    repeat (30) @(posedge clk);
    if (char_q.size() != 0) report_mismatch("characters never seen", char_q.size(), 0);
    $display("run covered %0d bytes in, %0d character beats out, %0d overflow beats",
             bytes_in, chars_out, overflow_beats);
    $display("over %0d capacity settings from 0 to 65535", settings_used);
    if (fails == 0) begin
      $display("base38_byte_stream_encoder regression: pass");
    end else begin
      $display("base38_byte_stream_encoder regression: fail");
    end
    $finish;
  end

endmodule
